// ===== src/motor_fader_position_controller_defines.svh =====
// Assertion macros for the motor fader position controller.
// Used by files that assert; no other dependencies.
`ifndef MOTOR_FADER_POSITION_CONTROLLER_DEFINES_SVH
`define MOTOR_FADER_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define MFPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/mfpc_pkg.sv =====
// Constants and codes for the motor fader position controller.
// No dependencies.
`default_nettype none

package mfpc_pkg;

    // parameter defaults
    localparam int FADER_COUNT_DEF   = 16;
    localparam int POSITION_BITS_DEF = 12;

    // item operations
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_MOVE        = 3'd1;
    localparam logic [2:0] OP_DIRECT      = 3'd2;
    localparam logic [2:0] OP_SUSPEND     = 3'd3;
    localparam logic [2:0] OP_TOUCH_RESET = 3'd4;

    // drive directions
    localparam logic [1:0] DIR_STANDBY = 2'd0;
    localparam logic [1:0] DIR_UP      = 2'd1;
    localparam logic [1:0] DIR_DOWN    = 2'd2;
    localparam logic [1:0] DIR_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_MOTOR_DEADBAND  = 3'd0;
    localparam logic [2:0] CFG_PWM_PERIOD      = 3'd1;
    localparam logic [2:0] CFG_DUTY_UP         = 3'd2;
    localparam logic [2:0] CFG_DUTY_DOWN       = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_DEADBAND = 3'd4;

    // configuration reset values
    localparam logic [7:0]  MOTOR_DEADBAND_RST  = 8'd31;
    localparam logic [7:0]  PWM_PERIOD_RST      = 8'd3;
    localparam logic [7:0]  DUTY_UP_RST         = 8'd1;
    localparam logic [7:0]  DUTY_DOWN_RST       = 8'd1;
    localparam logic [11:0] SAMPLE_DEADBAND_RST = 12'd7;

    // counter reloads and position limits
    localparam logic [4:0]  REPEAT_RELOAD  = 5'd31;
    localparam logic [7:0]  TIMEOUT_RELOAD = 8'd255;
    localparam logic [7:0]  HOLD_RELOAD    = 8'd255;
    localparam logic [11:0] FAST_LIMIT     = 12'd500;
    localparam logic [11:0] LOW_END        = 12'h01f;
    localparam logic [11:0] SLOW_ZONE      = 12'h180;

    // dynamic deadband steps
    localparam logic [4:0] REP_STEP_1 = 5'd4;
    localparam logic [4:0] REP_STEP_2 = 5'd8;
    localparam logic [4:0] REP_STEP_3 = 5'd16;
    localparam logic [7:0] BAND_1     = 8'd16;
    localparam logic [7:0] BAND_2     = 8'd32;
    localparam logic [7:0] BAND_3     = 8'd64;

endpackage

`default_nettype wire

// ===== src/motor_fader_position_controller.sv =====
// Motor fader position controller: per-fader state table in one memory.
// Depends on mfpc_pkg and motor_fader_position_controller_defines.svh.
//
// Usage: each input beat (i_valid/o_ready) names a fader and an operation:
// tick, move target, direct drive, suspend set/clear or touch reset. Every
// beat gives one result beat (o_valid/i_ready) with the fader's drive, the
// keep-change flag, suspend state and an error flag for a missing fader.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
// shared by all faders; write it only while no beat is in flight.
// An accepted beat enters the working stage, then the result register once
// that is free or emptying. Throughput: one beat per cycle while results
// are taken. The fader's table entry is read in the accept cycle and
// written back when the working stage advances; a beat on the same fader
// right behind takes the new entry from a forwarding register.
// Reset: all table entries read as zero through per-entry valid bits, and
// the configuration returns to its defaults; no clearing pass is needed.
// Receiver stall: the result register holds, the working stage holds
// behind it, and o_ready drops only when both are full.
`default_nettype none
`include "motor_fader_position_controller_defines.svh"

module motor_fader_position_controller import mfpc_pkg::*; #(
    parameter int FADER_COUNT   = FADER_COUNT_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_op,
    input  wire logic [4:0]  i_fader,
    input  wire logic [11:0] i_position,
    input  wire logic [11:0] i_sample_change,
    input  wire logic [1:0]  i_drive_request,
    input  wire logic        i_suspend_flag,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [4:0]       o_fader_out,
    output logic             o_drive_up,
    output logic             o_drive_down,
    output logic             o_keep_change,
    output logic             o_is_suspended,
    output logic             o_error
);

    localparam int AW = (FADER_COUNT > 1) ? $clog2(FADER_COUNT) : 1;
    localparam int TW = (POSITION_BITS < 12) ? POSITION_BITS : 12;
    localparam logic [5:0] FADER_LIMIT = 6'(FADER_COUNT);

    typedef struct packed {
        logic [TW-1:0] target;
        logic [4:0]    rep;
        logic [7:0]    tmo;
        logic [7:0]    hold;
        logic [7:0]    pwm;
        logic [1:0]    dir;
        logic          susp;
        logic          direct;
    } t_entry;

    // configuration
    logic [7:0]  r_motor_deadband;
    logic [7:0]  r_pwm_period;
    logic [7:0]  r_duty_up;
    logic [7:0]  r_duty_down;
    logic [11:0] r_sample_deadband;

    // state table
    t_entry             r_mem [FADER_COUNT];
    logic [FADER_COUNT-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic               r_fwd_hit;
    t_entry             r_fwd_data;

    // working stage
    logic          r_s1_valid;
    logic [2:0]    r_s1_op;
    logic [4:0]    r_s1_fader;
    logic [TW-1:0] r_s1_pos;
    logic [11:0]   r_s1_chg;
    logic [1:0]    r_s1_req;
    logic          r_s1_sus;
    logic          r_s1_inrange;

    // result register
    logic       r_out_valid;
    logic [4:0] r_fader_out;
    logic       r_drive_up;
    logic       r_drive_down;
    logic       r_keep_change;
    logic       r_is_suspended;
    logic       r_error;

    logic          accept;
    logic          in_range;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] s1_addr;
    logic          s1_go;
    logic          s1_write;

    t_entry        cur;
    t_entry        n_entry;
    logic          n_keep;
    logic          tk_idle;
    logic          tk_moving;
    logic          tk_above;
    logic [11:0]   tk_pos;
    logic [11:0]   tk_tgt;
    logic [11:0]   tk_dist;
    logic [7:0]    tk_band;
    logic [7:0]    tk_pwm;
    logic [7:0]    tk_duty;
    logic [1:0]    req;

    assign in_range = {1'b0, i_fader} < FADER_LIMIT;
    assign in_addr  = i_fader[AW-1:0];
    assign s1_addr  = r_s1_fader[AW-1:0];
    assign s1_go    = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_write = s1_go && r_s1_inrange;
    assign o_ready  = !r_s1_valid || s1_go;
    assign accept   = i_valid && o_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_deadband  <= MOTOR_DEADBAND_RST;
            r_pwm_period      <= PWM_PERIOD_RST;
            r_duty_up         <= DUTY_UP_RST;
            r_duty_down       <= DUTY_DOWN_RST;
            r_sample_deadband <= SAMPLE_DEADBAND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOTOR_DEADBAND:  r_motor_deadband  <= i_cfg_data[7:0];
                CFG_PWM_PERIOD:      r_pwm_period      <= i_cfg_data[7:0];
                CFG_DUTY_UP:         r_duty_up         <= i_cfg_data[7:0];
                CFG_DUTY_DOWN:       r_duty_down       <= i_cfg_data[7:0];
                CFG_SAMPLE_DEADBAND: r_sample_deadband <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table memory: read on accept, write back when the working stage advances
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (s1_write) begin
            r_mem[s1_addr] <= n_entry;
        end
        if (accept) begin
            r_fwd_data <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (s1_write) begin
                r_vld[s1_addr] <= 1'b1;
            end
            if (accept) begin
                r_rd_vld  <= in_range && r_vld[in_addr];
                // the write of this cycle is not yet in the read data
                r_fwd_hit <= s1_write && (r_s1_fader == i_fader);
            end
        end
    end

    // working stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= i_op;
            r_s1_fader   <= i_fader;
            r_s1_pos     <= i_position[TW-1:0];
            r_s1_chg     <= i_sample_change;
            r_s1_req     <= i_drive_request;
            r_s1_sus     <= i_suspend_flag;
            r_s1_inrange <= in_range;
        end
    end

    // read-modify of the fader entry
    always_comb begin
        cur       = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
        n_entry   = cur;
        n_keep    = 1'b0;
        tk_idle   = 1'b0;
        tk_moving = r_s1_chg > r_sample_deadband;
        tk_pos    = 12'(r_s1_pos);
        tk_tgt    = 12'(cur.target);
        tk_above  = 1'b0;
        tk_dist   = '0;
        tk_band   = '0;
        tk_pwm    = '0;
        tk_duty   = '0;
        req       = (r_s1_req == DIR_INVALID) ? DIR_STANDBY : r_s1_req;

        case (r_s1_op)
            OP_TICK: begin
                if (!cur.direct) begin
                    if (cur.hold != 8'd0) n_entry.hold = cur.hold - 8'd1;
                    if (cur.tmo != 8'd0) n_entry.tmo = cur.tmo - 8'd1;
                    if (cur.susp) begin
                        n_entry.rep = '0;
                        n_entry.tmo = '0;
                    end

                    if (n_entry.rep == 5'd0) begin
                        n_entry.dir = DIR_STANDBY;
                        tk_idle     = 1'b1;
                        if (n_entry.tmo != 8'd0) begin
                            n_entry.target = r_s1_pos;
                        end else if (tk_moving) begin
                            // follow the hand and hold off moves for a while
                            n_entry.target = r_s1_pos;
                            n_entry.hold   = HOLD_RELOAD;
                            n_keep         = 1'b1;
                        end
                    end else if (n_entry.tmo == 8'd0 && !tk_moving) begin
                        n_entry.rep = 5'd1;
                        tk_idle     = 1'b1;
                    end else if (tk_moving) begin
                        n_entry.tmo = TIMEOUT_RELOAD;
                    end

                    if (!tk_idle) begin
                        if (r_s1_chg > FAST_LIMIT) begin
                            n_entry.dir = DIR_STANDBY;
                        end else if (tk_tgt < LOW_END && tk_pos < LOW_END) begin
                            n_entry.dir = DIR_STANDBY;
                            n_entry.rep = n_entry.rep - 5'd1;
                        end else begin
                            tk_above = tk_pos > tk_tgt;
                            tk_dist  = tk_above ? tk_pos - tk_tgt : tk_tgt - tk_pos;
                            if (n_entry.rep < REP_STEP_1) begin
                                tk_band = BAND_1;
                            end else if (n_entry.rep < REP_STEP_2) begin
                                tk_band = BAND_2;
                            end else if (n_entry.rep < REP_STEP_3) begin
                                tk_band = BAND_3;
                            end else begin
                                tk_band = r_motor_deadband;
                            end
                            if (tk_dist <= 12'(tk_band)) begin
                                n_entry.rep = n_entry.rep - 5'd1;
                            end else if (r_pwm_period != 8'd0 && tk_dist < SLOW_ZONE) begin
                                // slow down near the target: drive only part of the period
                                tk_pwm = cur.pwm + 8'd1;
                                if (tk_pwm >= r_pwm_period) tk_pwm = 8'd0;
                                n_entry.pwm = tk_pwm;
                                tk_duty = tk_above ? r_duty_up : r_duty_down;
                                if (tk_pwm > tk_duty) tk_idle = 1'b1;
                            end
                            if (tk_idle) begin
                                n_entry.dir = DIR_STANDBY;
                            end else begin
                                n_entry.dir = tk_above ? DIR_UP : DIR_DOWN;
                            end
                        end
                    end
                end
            end
            OP_MOVE: begin
                if (cur.hold == 8'd0) begin
                    n_entry.target = r_s1_pos;
                    n_entry.rep    = REPEAT_RELOAD;
                    n_entry.tmo    = TIMEOUT_RELOAD;
                end
            end
            OP_DIRECT: begin
                n_entry.dir    = req;
                n_entry.direct = req != DIR_STANDBY;
            end
            OP_SUSPEND: begin
                if (r_s1_sus) begin
                    n_entry.susp = 1'b1;
                end else begin
                    n_entry.susp = 1'b0;
                    n_entry.hold = HOLD_RELOAD;
                end
            end
            OP_TOUCH_RESET: begin
                n_entry.hold = 8'd0;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_fader_out    <= r_s1_fader;
            r_drive_up     <= r_s1_inrange && (n_entry.dir == DIR_UP);
            r_drive_down   <= r_s1_inrange && (n_entry.dir == DIR_DOWN);
            r_keep_change  <= r_s1_inrange && n_keep;
            r_is_suspended <= r_s1_inrange && n_entry.susp;
            r_error        <= !r_s1_inrange;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fader_out    = r_fader_out;
    assign o_drive_up     = r_drive_up;
    assign o_drive_down   = r_drive_down;
    assign o_keep_change  = r_keep_change;
    assign o_is_suspended = r_is_suspended;
    assign o_error        = r_error;

    // checks
    `MFPC_ASSERT_NOW(a_err_quiet, i_clk, i_rst_n, o_valid && o_error,
        !o_drive_up && !o_drive_down && !o_keep_change && !o_is_suspended)
    `MFPC_ASSERT_NOW(a_one_dir, i_clk, i_rst_n, o_valid, !(o_drive_up && o_drive_down))
    `MFPC_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_go,
        r_s1_valid && $stable(r_s1_fader) && $stable(r_s1_op))
    `MFPC_ASSERT_NEXT(a_fwd_set, i_clk, i_rst_n,
        accept && s1_write && (r_s1_fader == i_fader), r_fwd_hit && r_s1_inrange)
    `MFPC_ASSERT_NOW(a_keep_tick, i_clk, i_rst_n, r_s1_valid && (r_s1_op != OP_TICK),
        !n_keep)

endmodule

`default_nettype wire
